/* design/lte_pkg.sv */
`default_nettype none

package lte_pkg;

	// One line-table entry or a finish command.
	typedef struct packed {
		logic        cmd;
		logic [23:0] address;
		logic [31:0] line;
		logic [15:0] column;
		logic [23:0] file_index;
	} entry_t;

	// One byte of the line number program.
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        status;
		logic        last;
		logic [31:0] unit_len;
	} result_t;

	// Which parts of the program a job asks for, in program order.
	typedef struct packed {
		logic err;
		logic end_seq;
		logic set_addr;
		logic set_file;
		logic set_col;
		logic adv_line;
		logic copy;
		logic fin;
	} job_flags_t;

	typedef struct packed {
		job_flags_t         flags;
		logic [23:0]        address;
		logic [23:0]        file;
		logic [13:0]        column;
		logic signed [20:0] delta;
	} job_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Line folding: line mod 100000 through a reciprocal multiply.
	localparam logic [31:0] LINE_FOLD_ABOVE = 32'd1000000;
	localparam logic [17:0] LINE_FOLD_MOD   = 18'd100000;
	localparam logic [31:0] FOLD_RECIP      = 32'd2814749767;
	localparam int          FOLD_SHIFT      = 48;
	localparam int          FOLD_Q_W        = 16;
	localparam logic [15:0] COLUMN_MAX      = 16'd10000;

	localparam logic [19:0] ROW_LINE_RESET = 20'd1;
	localparam logic [23:0] ROW_FILE_RESET = 24'd1;

	// Opcodes and fixed program bytes.
	localparam logic [7:0] OP_EXTENDED     = 8'h00;
	localparam logic [7:0] OP_COPY         = 8'h01;
	localparam logic [7:0] OP_ADVANCE_LINE = 8'h03;
	localparam logic [7:0] OP_SET_FILE     = 8'h04;
	localparam logic [7:0] OP_SET_COLUMN   = 8'h05;
	localparam logic [7:0] LNE_END_SEQ     = 8'h01;
	localparam logic [7:0] LNE_SET_ADDRESS = 8'h02;
	localparam logic [7:0] END_SEQ_LEN     = 8'h01;

	localparam logic [31:0] UNIT_LEN_BIAS = 32'd4;

endpackage

`default_nettype wire

/* design/line_table_entry_encoder_unit.sv */
`default_nettype none

// Line-table entry encoder: turns line-table entries and finish commands into the bytes
// of a DWARF line number program, one result item per byte.
// Input channel: an item (entry) is taken at a clock edge with push high and full low.
// Result channel: the oldest byte sits on result while empty is low and is taken at an
// edge with pop high. The last byte caused by one input item carries last; the final byte
// of a finish carries the unit length.
// Path: the front runs a three-stage pipeline (line folding by reciprocal multiply, then
// row compare), the job then enters a four-job queue, the back takes it from there and
// writes its first byte into the output register.
// Throughput: the back emits one byte per cycle while the receiver keeps popping, with
// no gap between queued jobs; an item causes 1 to 27 bytes. Items that cause no bytes push no
// job and stop in the front.
// Reset clears the row to address 0, line 1, column 0, file 1, the finished flag and
// the byte count; no clearing pass is needed.
// When the receiver stalls, the output register holds its byte, the back waits, the job
// queue fills and then full rises until there is room again; nothing is dropped.

module line_table_entry_encoder_unit #(
	parameter int ADDRESS_BYTES      = 8,
	parameter int ADDRESS_LIMIT_BITS = 20
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire lte_pkg::entry_t  entry,
	output logic                  empty,
	input  wire logic             pop,
	output lte_pkg::result_t      result
);

	logic          job_push, job_full, job_empty, job_take;
	lte_pkg::job_t job_in, job_out;

	// Front: folds line, zeroes an oversized column, checks the address range and compares with the row.
	lte_front #(
		.ADDRESS_LIMIT_BITS(ADDRESS_LIMIT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.entry    (entry),
		.job_push (job_push),
		.job      (job_in),
		.job_full (job_full)
	);

	// Jobs wait here so that the front keeps taking items while bytes drain.
	lte_job_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wdata  (job_in),
		.full   (job_full),
		.rd     (job_take),
		.rdata  (job_out),
		.empty  (job_empty)
	);

	// Back: walks each job's opcodes and LEB128 operands one byte per cycle, unless the receiver stalls.
	lte_back #(
		.ADDRESS_BYTES(ADDRESS_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.job_empty (job_empty),
		.job_take  (job_take),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

	// Input back-pressure only comes from a full job queue.
	a_full_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> job_full)
		else $error("full raised while the job queue had room");

	// The error result for a repeated finish is a lone, empty item.
	a_status_item: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status) |-> (result.last && result.out_byte == 8'h00))
		else $error("status item is not a lone final item");

	// A unit length only travels with the closing byte of a run.
	a_unit_len_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.unit_len != 32'd0) |-> result.last)
		else $error("unit length on a byte that is not last");

	// A job taken into an idle back passes the phase register, then puts its first byte on result.
	a_take_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(job_take && empty) |-> ##2 !empty)
		else $error("job taken into an idle back without a byte following");

endmodule

`default_nettype wire

/* design/lte_front.sv */
`default_nettype none

module lte_front #(
	parameter int ADDRESS_LIMIT_BITS = 20
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire lte_pkg::entry_t entry,
	output logic                 job_push,
	output lte_pkg::job_t        job,
	input  wire logic            job_full
);

	localparam int ROW_A_W = (ADDRESS_LIMIT_BITS < 24) ? ADDRESS_LIMIT_BITS : 24;

	logic                            adv;
	logic                            v_s1, v_s2, v_s3;
	lte_pkg::entry_t                 ent_s1, ent_s2;
	logic [lte_pkg::FOLD_Q_W-1:0]    q_s1;
	logic [17:0]                     qm_s2;
	logic [63:0]                     prod;
	logic [17:0]                     rem_raw, rem_fix;
	logic                            cmd_s3, inr_s3;
	logic [23:0]                     addr_s3, file_s3;
	logic [19:0]                     line_s3;
	logic [13:0]                     col_s3;

	logic [ROW_A_W-1:0]              row_addr_q;
	logic [19:0]                     row_line_q;
	logic [13:0]                     row_col_q;
	logic [23:0]                     row_file_q;
	logic                            finished_q;

	logic [23:0]                     ea;
	logic [19:0]                     el;
	logic [13:0]                     ec;
	logic [23:0]                     ef;
	logic                            backward, chg_a, chg_l, chg_c, any_chg, need_job;

	// The whole front stalls when the last stage cannot hand its job on.
	assign adv  = !(v_s3 && job_full);
	assign full = !adv;

	assign prod = entry.line * lte_pkg::FOLD_RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		rem_raw = ent_s2.line[17:0] - qm_s2;
		rem_fix = (rem_raw >= lte_pkg::LINE_FOLD_MOD) ? rem_raw - lte_pkg::LINE_FOLD_MOD
			: rem_raw;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s1  <= entry;
			q_s1    <= prod[lte_pkg::FOLD_SHIFT +: lte_pkg::FOLD_Q_W];
			ent_s2  <= ent_s1;
			qm_s2   <= 18'(q_s1 * lte_pkg::LINE_FOLD_MOD);
			cmd_s3  <= ent_s2.cmd;
			addr_s3 <= ent_s2.address;
			inr_s3  <= (({8'b0, ent_s2.address} >> ADDRESS_LIMIT_BITS) == 32'd0);
			line_s3 <= (ent_s2.line > lte_pkg::LINE_FOLD_ABOVE) ? {2'b0, rem_fix}
				: ent_s2.line[19:0];
			col_s3  <= (ent_s2.column > lte_pkg::COLUMN_MAX) ? 14'd0 : ent_s2.column[13:0];
			file_s3 <= ent_s2.file_index;
		end
	end

	// Compare against the row, which a backward address first puts back to its reset values.
	always_comb begin
		backward = (addr_s3 < 24'(row_addr_q)) && (row_addr_q != '0);
		ea       = backward ? 24'd0 : 24'(row_addr_q);
		el       = backward ? lte_pkg::ROW_LINE_RESET : row_line_q;
		ec       = backward ? 14'd0 : row_col_q;
		ef       = backward ? lte_pkg::ROW_FILE_RESET : row_file_q;
		chg_a    = addr_s3 != ea;
		chg_l    = line_s3 != el;
		chg_c    = col_s3 != ec;
		any_chg  = chg_a || chg_l || chg_c;

		job          = '0;
		job.address  = addr_s3;
		job.file     = file_s3;
		job.column   = col_s3;
		job.delta    = $signed({1'b0, line_s3}) - $signed({1'b0, el});
		if (cmd_s3) begin
			job.flags.err     = finished_q;
			job.flags.end_seq = !finished_q;
			job.flags.fin     = !finished_q;
			need_job          = 1'b1;
		end else begin
			job.flags.end_seq  = backward;
			job.flags.set_addr = any_chg && chg_a;
			job.flags.set_file = any_chg && (file_s3 != ef);
			job.flags.set_col  = any_chg && chg_c;
			job.flags.adv_line = any_chg && chg_l;
			job.flags.copy     = any_chg;
			need_job           = inr_s3 && (backward || any_chg);
		end
	end

	assign job_push = v_s3 && adv && need_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_addr_q <= '0;
			row_line_q <= lte_pkg::ROW_LINE_RESET;
			row_col_q  <= '0;
			row_file_q <= lte_pkg::ROW_FILE_RESET;
			finished_q <= 1'b0;
		end else if (job_push) begin
			if (cmd_s3) begin
				finished_q <= 1'b1;
			end else if (any_chg) begin
				row_addr_q <= addr_s3[ROW_A_W-1:0];
				row_line_q <= line_s3;
				row_col_q  <= col_s3;
				row_file_q <= file_s3;
			end else begin
				row_addr_q <= '0;
				row_line_q <= lte_pkg::ROW_LINE_RESET;
				row_col_q  <= '0;
				row_file_q <= lte_pkg::ROW_FILE_RESET;
			end
		end
	end

endmodule

`default_nettype wire

/* design/lte_job_queue.sv */
`default_nettype none

module lte_job_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  wire lte_pkg::job_t wdata,
	output logic               full,
	input  wire logic          rd,
	output lte_pkg::job_t      rdata,
	output logic               empty
);

	lte_pkg::job_t                   slots [lte_pkg::QUEUE_DEPTH];
	logic [lte_pkg::QUEUE_PTR_W-1:0] wp_q, rp_q;
	logic [lte_pkg::QUEUE_CNT_W-1:0] cnt_q;
	logic                            do_wr, do_rd;

	localparam logic [lte_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
		lte_pkg::QUEUE_PTR_W'(lte_pkg::QUEUE_DEPTH - 1);
	localparam logic [lte_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
		lte_pkg::QUEUE_CNT_W'(lte_pkg::QUEUE_DEPTH);

	assign full  = cnt_q == CNT_FULL;
	assign empty = cnt_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = slots[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/lte_back.sv */
`default_nettype none

module lte_back #(
	parameter int ADDRESS_BYTES = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lte_pkg::job_t job,
	input  wire logic          job_empty,
	output logic               job_take,
	output lte_pkg::result_t   result,
	output logic               empty,
	input  wire logic          pop
);

	localparam int AB_W = $clog2(ADDRESS_BYTES);
	localparam logic [AB_W-1:0] AB_LAST = AB_W'(ADDRESS_BYTES - 1);
	localparam logic [7:0] ADDR_LEN_BYTE = 8'(ADDRESS_BYTES + 1);

	typedef enum logic [3:0] {
		PH_END0, PH_END1, PH_END2, PH_AOP, PH_ALEN, PH_ASUB, PH_ABYTE,
		PH_FOP, PH_FVAL, PH_COP, PH_CVAL, PH_LOP, PH_LVAL, PH_COPY, PH_ERR, PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		SEC_START, SEC_AFTER_END, SEC_AFTER_ADDR, SEC_AFTER_FILE, SEC_AFTER_COL,
		SEC_AFTER_LINE
	} section_t;

	// First part of the job that is still wanted at or after the given point.
	function automatic phase_t pick(lte_pkg::job_flags_t f, section_t from);
		phase_t ph;
		ph = PH_DONE;
		if (f.copy) ph = PH_COPY;
		if (from <= SEC_AFTER_COL && f.adv_line) ph = PH_LOP;
		if (from <= SEC_AFTER_FILE && f.set_col) ph = PH_COP;
		if (from <= SEC_AFTER_ADDR && f.set_file) ph = PH_FOP;
		if (from <= SEC_AFTER_END && f.set_addr) ph = PH_AOP;
		if (from == SEC_START && f.end_seq) ph = PH_END0;
		if (from == SEC_START && f.err) ph = PH_ERR;
		return ph;
	endfunction

	phase_t             ph_q, nxt;
	logic               busy_q, ov_q;
	lte_pkg::job_t      job_q;
	logic [23:0]        val_q, val_n, ash_q, ash_n, val_rest;
	logic signed [20:0] sl_q, sl_n, sl_rest;
	logic [AB_W-1:0]    ab_q, ab_n;
	logic [31:0]        cnt_q;
	logic [7:0]         byte_c;
	logic               status_c, last_c, sl_done, emit, load;
	lte_pkg::result_t   out_q;

	assign val_rest = val_q >> 7;
	assign sl_rest  = sl_q >>> 7;
	assign sl_done  = ((sl_rest == '0) && !sl_q[6]) || ((sl_rest == '1) && sl_q[6]);

	always_comb begin
		byte_c   = 8'h00;
		status_c = 1'b0;
		nxt      = ph_q;
		val_n    = val_q;
		sl_n     = sl_q;
		ash_n    = ash_q;
		ab_n     = ab_q;
		case (ph_q)
			PH_END0: begin
				byte_c = lte_pkg::OP_EXTENDED;
				nxt    = PH_END1;
			end
			PH_END1: begin
				byte_c = lte_pkg::END_SEQ_LEN;
				nxt    = PH_END2;
			end
			PH_END2: begin
				byte_c = lte_pkg::LNE_END_SEQ;
				nxt    = pick(job_q.flags, SEC_AFTER_END);
			end
			PH_AOP: begin
				byte_c = lte_pkg::OP_EXTENDED;
				nxt    = PH_ALEN;
			end
			PH_ALEN: begin
				byte_c = ADDR_LEN_BYTE;
				nxt    = PH_ASUB;
			end
			PH_ASUB: begin
				byte_c = lte_pkg::LNE_SET_ADDRESS;
				ash_n  = job_q.address;
				ab_n   = '0;
				nxt    = PH_ABYTE;
			end
			PH_ABYTE: begin
				byte_c = ash_q[7:0];
				if (ab_q == AB_LAST) begin
					nxt = pick(job_q.flags, SEC_AFTER_ADDR);
				end else begin
					ab_n  = ab_q + 1'b1;
					ash_n = ash_q >> 8;
				end
			end
			PH_FOP: begin
				byte_c = lte_pkg::OP_SET_FILE;
				val_n  = job_q.file;
				nxt    = PH_FVAL;
			end
			PH_FVAL: begin
				byte_c = {(val_rest != '0), val_q[6:0]};
				val_n  = val_rest;
				if (val_rest == '0) begin
					nxt = pick(job_q.flags, SEC_AFTER_FILE);
				end
			end
			PH_COP: begin
				byte_c = lte_pkg::OP_SET_COLUMN;
				val_n  = 24'(job_q.column);
				nxt    = PH_CVAL;
			end
			PH_CVAL: begin
				byte_c = {(val_rest != '0), val_q[6:0]};
				val_n  = val_rest;
				if (val_rest == '0) begin
					nxt = pick(job_q.flags, SEC_AFTER_COL);
				end
			end
			PH_LOP: begin
				byte_c = lte_pkg::OP_ADVANCE_LINE;
				sl_n   = job_q.delta;
				nxt    = PH_LVAL;
			end
			PH_LVAL: begin
				byte_c = {!sl_done, sl_q[6:0]};
				sl_n   = sl_rest;
				if (sl_done) begin
					nxt = pick(job_q.flags, SEC_AFTER_LINE);
				end
			end
			PH_COPY: begin
				byte_c = lte_pkg::OP_COPY;
				nxt    = PH_DONE;
			end
			PH_ERR: begin
				status_c = 1'b1;
				nxt      = PH_DONE;
			end
			default: begin
				nxt = PH_DONE;
			end
		endcase
		last_c = nxt == PH_DONE;
	end

	// While the back is busy, a byte moves into the output register whenever that register is free or being drained.
	assign emit     = busy_q && (!ov_q || pop);
	assign load     = !job_empty && (!busy_q || (emit && last_c));
	assign job_take = load;
	assign empty    = !ov_q;
	assign result   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_DONE;
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
			cnt_q  <= '0;
			job_q  <= '0;
			val_q  <= '0;
			sl_q   <= '0;
			ash_q  <= '0;
			ab_q   <= '0;
			out_q  <= '0;
		end else begin
			if (emit) begin
				ov_q                 <= 1'b1;
				out_q.out_byte       <= byte_c;
				out_q.status         <= status_c;
				out_q.last           <= last_c;
				out_q.unit_len       <= (job_q.flags.fin && last_c)
					? cnt_q + 32'd1 + lte_pkg::UNIT_LEN_BIAS : 32'd0;
				if (!status_c) begin
					cnt_q <= cnt_q + 32'd1;
				end
				val_q <= val_n;
				sl_q  <= sl_n;
				ash_q <= ash_n;
				ab_q  <= ab_n;
			end else if (pop) begin
				ov_q <= 0;
			end
			// A new job takes over the phase as the previous one ends, or when the back is idle.
			if (load) begin
				job_q  <= job;
				ph_q   <= pick(job.flags, SEC_START);
				busy_q <= 1'b1;
			end else if (emit) begin
				ph_q <= nxt;
				if (last_c) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire
